// ----- rtl/core/smlp_pkg.sv -----
// Package for the SML stream parser with CRC-16/X.25 check.
// Holds parser state codes, stream constants and default parameter values.
// Depends on nothing.
package smlp_pkg;

    typedef enum logic [4:0] {
        ST_START      = 5'd0,
        ST_VERSION    = 5'd1,
        ST_BLOCKSTART = 5'd2,
        ST_BLOCKEND   = 5'd3,
        ST_LISTSTART  = 5'd4,
        ST_LISTEND    = 5'd5,
        ST_NEXT       = 5'd6,
        ST_DATA       = 5'd7,
        ST_SIGNED     = 5'd8,
        ST_UNSIGNED   = 5'd9,
        ST_OCTET      = 5'd10,
        ST_DATAEND    = 5'd11,
        ST_LONGLEN    = 5'd12,
        ST_END        = 5'd13,
        ST_CHECKSUM   = 5'd14,
        ST_CRCERROR   = 5'd15,
        ST_UNEXPECTED = 5'd16,
        ST_FINAL      = 5'd17
    } parse_state_t;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CRC,
        PH_POP,
        PH_DECODE,
        PH_PRESET,
        PH_OUT
    } phase_t;

    localparam logic [7:0]  ESC_BYTE    = 8'h1B;
    localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam int          TREE_DEPTH_DEF    = 8;
    localparam int          LIST_CAPACITY_DEF = 128;

    // CRC unit control
    typedef struct packed {
        logic       load;      // load crc register with preset
        logic       feed;      // xor a byte into low bits
        logic       shift;     // one reflected shift step
        logic [7:0] feed_byte;
    } crc_ctl_t;

endpackage

// ----- rtl/core/smlp_stream_if.sv -----
// Valid/ready stream interface carrying one beat of payload.
// Depends on nothing.
interface smlp_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sml_stream_parser_crc16.sv -----
// SML stream parser, one byte per input beat, one result beat per byte.
// Channels: in_ch (data_byte) and out_ch (parse state, tree level, list pushes).
// Flow per byte: the byte is taken when the block is idle and no result is
// waiting, and it is xored into the CRC register in that cycle. The shared CRC
// unit then shifts the byte through, one bit per cycle. Next come the pop phase,
// which drops each empty tree level in turn, the decode phase and the phase
// that loads the output register.
// The block takes no new byte until the result beat of the last one has been
// taken. After the last byte of the start escape the CRC unit is preset and
// four 0x1B bytes are replayed through it before the result beat is loaded.
// The result sits in an output register until taken, and the next byte is only
// accepted in the cycle after the result beat moves, so a stalled receiver
// stalls the input.
// Reset: state start, CRC preset 0xFFFF, all tree counts and list fill zero.
// Depends on smlp_pkg, smlp_stream_if, smlp_crc_unit.
module sml_stream_parser_crc16 #(
    parameter int TREE_DEPTH    = smlp_pkg::TREE_DEPTH_DEF,
    parameter int LIST_CAPACITY = smlp_pkg::LIST_CAPACITY_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    smlp_stream_if.sink  in_ch,
    smlp_stream_if.source out_ch
);
    localparam int LW = $clog2(TREE_DEPTH + 1);
    localparam logic [3:0] TOP = 4'(TREE_DEPTH);
    localparam logic [7:0] CAP = 8'(LIST_CAPACITY);

    typedef smlp_pkg::parse_state_t st_t;

    // state
    smlp_pkg::phase_t phase_reg, phase_next;
    st_t         pst_reg, pst_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] crcc_reg, crcc_next;
    logic [15:0] crcr_reg, crcr_next;
    logic [3:0]  lvl_reg, lvl_next;
    logic [3:0]  cnt_reg [TREE_DEPTH+1];
    logic [3:0]  cnt_next [TREE_DEPTH+1];
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  byte_reg, byte_next;
    logic [5:0]  step_reg, step_next;
    logic [2:0]  sub_reg, sub_next;     // escape bytes left to replay
    logic        ovalid_reg, ovalid_next;
    logic        clr_reg, clr_next;
    logic [1:0]  npush_reg, npush_next;
    logic [7:0]  p0_reg, p0_next, p1_reg, p1_next;

    smlp_pkg::crc_ctl_t crc_ctl;
    logic [15:0] crc;
    logic        replay;

    smlp_crc_unit u_crc (.clk(clk), .rst_n(rst_n), .ctl(crc_ctl), .crc(crc));

    logic [LW-1:0] li;
    assign li = lvl_reg[LW-1:0];

    // handshake
    assign in_ch.ready  = (phase_reg == smlp_pkg::PH_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = {5'(pst_reg), lvl_reg, clr_reg, npush_reg, p0_reg, p1_reg, fill_reg};

    // does the decode need to pop empty levels first
    logic tl_state;
    always_comb
    begin
        unique case (pst_reg)
            smlp_pkg::ST_DATAEND, smlp_pkg::ST_NEXT, smlp_pkg::ST_LISTSTART,
            smlp_pkg::ST_LISTEND, smlp_pkg::ST_BLOCKSTART, smlp_pkg::ST_BLOCKEND:
                tl_state = 1'b1;
            default: tl_state = 1'b0;
        endcase
    end

    // next-state sequencer
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            smlp_pkg::PH_IDLE:
                if (in_ch.valid && in_ch.ready) phase_next = smlp_pkg::PH_CRC;
            smlp_pkg::PH_CRC:
                if (step_reg == 6'd1) phase_next = smlp_pkg::PH_POP;
            smlp_pkg::PH_POP:
                if (!tl_state || lvl_reg == 4'd0 || cnt_reg[li] != 4'd0)
                    phase_next = smlp_pkg::PH_DECODE;
            smlp_pkg::PH_DECODE:
                phase_next = replay ? smlp_pkg::PH_PRESET : smlp_pkg::PH_OUT;
            smlp_pkg::PH_PRESET:
                if (step_reg == 6'd1 && sub_reg == 3'd0) phase_next = smlp_pkg::PH_OUT;
            smlp_pkg::PH_OUT:
                phase_next = smlp_pkg::PH_IDLE;
            default: phase_next = smlp_pkg::PH_IDLE;
        endcase
    end

    // datapath
    logic [7:0] b;
    logic [7:0] rem_dec;
    logic [3:0] size_n;
    logic [7:0] size8;
    logic [7:0] f;
    logic [1:0] np;
    logic [7:0] q0, q1;
    logic [7:0] pv [2];

    always_comb
    begin
        b = byte_reg;
        pst_next = pst_reg; rem_next = rem_reg; crcc_next = crcc_reg; crcr_next = crcr_reg;
        lvl_next = lvl_reg; cnt_next = cnt_reg; fill_next = fill_reg;
        byte_next = byte_reg; step_next = step_reg; ovalid_next = ovalid_reg;
        sub_next = sub_reg;
        clr_next = clr_reg; npush_next = npush_reg; p0_next = p0_reg; p1_next = p1_reg;
        crc_ctl = '0;
        replay = 1'b0;
        rem_dec = 8'd0; size_n = 4'd0; size8 = 8'd0;
        f = fill_reg; np = 2'd0; q0 = 8'd0; q1 = 8'd0;
        pv[0] = 8'd0; pv[1] = 8'd0;

        if (out_ch.valid && out_ch.ready) ovalid_next = 1'b0;

        unique case (phase_reg)
            smlp_pkg::PH_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    byte_next = in_ch.data;
                    crc_ctl.feed = 1'b1;
                    crc_ctl.feed_byte = in_ch.data;
                    step_next = 6'd8;
                end
            smlp_pkg::PH_CRC:
                if (step_reg != 6'd0)
                begin
                    crc_ctl.shift = 1'b1;
                    step_next = step_reg - 6'd1;
                end
            smlp_pkg::PH_POP:
                if (tl_state && lvl_reg != 4'd0 && cnt_reg[li] == 4'd0)
                    lvl_next = lvl_reg - 4'd1;
            smlp_pkg::PH_DECODE:
            begin
                rem_dec = (rem_reg != 8'd0) ? rem_reg - 8'd1 : 8'd0;
                rem_next = rem_dec;
                clr_next = 1'b0;
                unique case (pst_reg)
                    smlp_pkg::ST_VERSION:
                    begin
                        if (b != 8'h01)
                        begin
                            pst_next = smlp_pkg::ST_UNEXPECTED;
                            rem_next = 8'd4;
                        end
                        if (rem_next == 8'd0)
                        begin
                            pst_next = smlp_pkg::ST_BLOCKSTART;
                            rem_next = 8'd1;
                        end
                    end
                    smlp_pkg::ST_END:
                    begin
                        if (b != smlp_pkg::ESC_BYTE)
                        begin
                            pst_next = smlp_pkg::ST_UNEXPECTED;
                            rem_next = 8'd4;
                        end
                        if (rem_next == 8'd0)
                        begin
                            pst_next = smlp_pkg::ST_CHECKSUM;
                            rem_next = 8'd4;
                        end
                    end
                    smlp_pkg::ST_CHECKSUM:
                    begin
                        if (rem_dec == 8'd2) crcc_next = crc ^ 16'hFFFF;
                        if (rem_dec == 8'd1) crcr_next = crcr_reg + {8'd0, b};
                        if (rem_dec == 8'd0)
                        begin
                            pst_next = (crcc_reg == (crcr_reg | {b, 8'd0})) ?
                                       smlp_pkg::ST_FINAL : smlp_pkg::ST_CRCERROR;
                            rem_next = 8'd4;
                            crc_ctl.load = 1'b1;
                            crcr_next = 16'd0;
                        end
                    end
                    smlp_pkg::ST_LONGLEN:
                    begin
                        size8 = rem_dec + b - 8'd1;
                        pst_next = smlp_pkg::ST_DATA; rem_next = size8;
                        q0 = size8; q1 = 8'(smlp_pkg::ST_DATA); np = 2'd2;
                    end
                    smlp_pkg::ST_DATA, smlp_pkg::ST_SIGNED, smlp_pkg::ST_UNSIGNED,
                    smlp_pkg::ST_OCTET:
                    begin
                        q0 = b; np = 2'd1;
                        if (rem_dec == 8'd0)
                            pst_next = (cnt_reg[li] == 4'd0) ? smlp_pkg::ST_LISTEND
                                                             : smlp_pkg::ST_DATAEND;
                    end
                    smlp_pkg::ST_DATAEND, smlp_pkg::ST_NEXT, smlp_pkg::ST_LISTSTART,
                    smlp_pkg::ST_LISTEND, smlp_pkg::ST_BLOCKSTART, smlp_pkg::ST_BLOCKEND:
                    begin
                        size_n = b[3:0];
                        if (b > 8'h70 && b < 8'h7F)
                        begin
                            if (cnt_reg[li] != 4'd0) cnt_next[li] = cnt_reg[li] - 4'd1;
                            if (lvl_reg < TOP) lvl_next = lvl_reg + 4'd1;
                            cnt_next[lvl_next[LW-1:0]] = size_n;
                            pst_next = smlp_pkg::ST_LISTSTART; rem_next = {4'd0, size_n};
                            if (size_n > 4'd5)
                            begin
                                f = 8'd0;
                                clr_next = 1'b1;
                            end
                            else
                            begin
                                q0 = {4'd0, size_n};
                                q1 = 8'(smlp_pkg::ST_LISTSTART);
                                np = 2'd2;
                            end
                        end
                        else if (b >= 8'h01 && b <= 8'h6F && cnt_reg[li] != 4'd0)
                        begin
                            if (b == 8'h01)
                            begin
                                q0 = 8'd0; q1 = 8'(pst_reg); np = 2'd2;
                                pst_next = (cnt_reg[li] == 4'd1) ? smlp_pkg::ST_LISTEND
                                                                 : smlp_pkg::ST_NEXT;
                                rem_next = 8'd1;
                            end
                            else
                            begin
                                size8 = {4'd0, size_n} - 8'd1;
                                case (b[7:4])
                                    4'h5: pst_next = smlp_pkg::ST_SIGNED;
                                    4'h6: pst_next = smlp_pkg::ST_UNSIGNED;
                                    4'h0: pst_next = smlp_pkg::ST_OCTET;
                                    default: pst_next = smlp_pkg::ST_DATA;
                                endcase
                                rem_next = size8;
                                q0 = size8; q1 = 8'(pst_next); np = 2'd2;
                            end
                            cnt_next[li] = cnt_reg[li] - 4'd1;
                        end
                        else if (b == 8'h00)
                        begin
                            if (cnt_reg[li] != 4'd0) cnt_next[li] = cnt_reg[li] - 4'd1;
                            pst_next = (lvl_reg == 4'd0) ? smlp_pkg::ST_NEXT
                                                         : smlp_pkg::ST_BLOCKEND;
                            rem_next = 8'd1;
                        end
                        else if (b[7:4] == 4'h8)
                        begin
                            pst_next = smlp_pkg::ST_LONGLEN; rem_next = {size_n, 4'd0};
                        end
                        else if (b == smlp_pkg::ESC_BYTE && lvl_reg == 4'd0)
                        begin
                            pst_next = smlp_pkg::ST_END; rem_next = 8'd3;
                        end
                        else
                        begin
                            pst_next = smlp_pkg::ST_UNEXPECTED; rem_next = 8'd4;
                        end
                    end
                    default:
                    begin
                        pst_next = smlp_pkg::ST_START;
                        lvl_next = 4'd0;
                        if (b != smlp_pkg::ESC_BYTE)
                        begin
                            pst_next = smlp_pkg::ST_UNEXPECTED;
                            rem_next = 8'd4;
                        end
                        if (rem_next == 8'd0)
                        begin
                            // preset, then replay the four escape bytes
                            crc_ctl.load = 1'b1;
                            replay = 1'b1;
                            pst_next = smlp_pkg::ST_VERSION; rem_next = 8'd4;
                            step_next = 6'd0;
                            sub_next = 3'd4;
                        end
                    end
                endcase
                // list buffer appends, dropping when full
                pv[0] = q0; pv[1] = q1;
                p0_next = 8'd0; p1_next = 8'd0; npush_next = 2'd0;
                if (np >= 2'd1 && f < CAP)
                begin
                    f = f + 8'd1;
                    p0_next = pv[0];
                    npush_next = 2'd1;
                end
                if (np == 2'd2 && f < CAP)
                begin
                    f = f + 8'd1;
                    if (npush_next == 2'd1)
                    begin
                        p1_next = pv[1];
                        npush_next = 2'd2;
                    end
                    else
                    begin
                        p0_next = pv[1];
                        npush_next = 2'd1;
                    end
                end
                fill_next = f;
            end
            smlp_pkg::PH_PRESET:
                // one feed step, then eight shifts, per escape byte
                if (step_reg != 6'd0)
                begin
                    crc_ctl.shift = 1'b1;
                    step_next = step_reg - 6'd1;
                end
                else
                begin
                    crc_ctl.feed = 1'b1;
                    crc_ctl.feed_byte = smlp_pkg::ESC_BYTE;
                    step_next = 6'd8;
                    sub_next = sub_reg - 3'd1;
                end
            smlp_pkg::PH_OUT:
                ovalid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= smlp_pkg::PH_IDLE;
            pst_reg    <= smlp_pkg::ST_START;
            rem_reg    <= 8'd4;
            crcc_reg   <= 16'd0;
            crcr_reg   <= 16'd0;
            lvl_reg    <= 4'd0;
            for (int i = 0; i <= TREE_DEPTH; i++) cnt_reg[i] <= 4'd0;
            fill_reg   <= 8'd0;
            ovalid_reg <= 1'b0;
            step_reg   <= 6'd0;
            sub_reg    <= 3'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pst_reg    <= pst_next;
            rem_reg    <= rem_next;
            crcc_reg   <= crcc_next;
            crcr_reg   <= crcr_next;
            lvl_reg    <= lvl_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            sub_reg    <= sub_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        clr_reg   <= clr_next;
        npush_reg <= npush_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
    end
endmodule

// ----- rtl/core/smlp_crc_unit.sv -----
// Shared bit-serial CRC-16/X.25 register: one reflected shift per cycle.
// Depends on smlp_pkg.
module smlp_crc_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  smlp_pkg::crc_ctl_t ctl,
    output logic [15:0]       crc
);
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // preset, byte xor or one shift step
    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.load)
            crc_next = smlp_pkg::CRC_PRESET;
        else if (ctl.feed)
            crc_next = crc_reg ^ {8'd0, ctl.feed_byte};
        else if (ctl.shift)
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ smlp_pkg::CRC_POLY) : (crc_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= smlp_pkg::CRC_PRESET;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;
endmodule

// ----- sim/sml_stream_parser_crc16_test_if.sv -----
// Interfaces used by the parser testbench come from the RTL.
// This file only fixes the result beat layout shared by the testbench top.
// Depends on smlp_pkg.
`timescale 1ns / 100ps
package smlp_test_pkg;
    import smlp_pkg::*;

    // one result beat, first field in the top bits
    typedef struct packed {
        parse_state_t st;
        logic [3:0]   level;
        logic         clear;
        logic [1:0]   count;
        logic [7:0]   first;
        logic [7:0]   second;
        logic [7:0]   fill;
    } parse_result_t;

    localparam int RESULT_W = $bits(parse_result_t);
endpackage

// ----- sim/sml_stream_parser_crc16_test.sv -----
// Testbench for the SML stream parser: drives byte beats, predicts every
// result beat from its own parser model and compares field by field.
// Depends on smlp_pkg, smlp_test_pkg, smlp_stream_if and the parser RTL.
`timescale 1ns / 100ps
module sml_stream_parser_crc16_test;
    import smlp_pkg::*;
    import smlp_test_pkg::*;

    localparam int DEPTH    = 8;
    localparam int CAPACITY = 128;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smlp_stream_if #(.WIDTH(8))        in_ch ();
    smlp_stream_if #(.WIDTH(RESULT_W)) out_ch ();

    sml_stream_parser_crc16 #(.TREE_DEPTH(DEPTH), .LIST_CAPACITY(CAPACITY)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // parser shadow state
    parse_state_t p_state;
    logic [7:0]   p_remain;
    logic [15:0]  p_crc;
    logic [15:0]  p_crc_calc;
    logic [15:0]  p_crc_rcvd;
    logic [3:0]   p_level;
    logic [3:0]   p_nodes [0:DEPTH];
    logic [7:0]   p_fill;
    int           n_pushed;
    logic [7:0]   pushed [0:1];
    logic         cleared;

    parse_result_t expected_results [$];
    int errors = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int hold_req = 0;

    function automatic void crc_byte(logic [7:0] b);
        logic [15:0] c;
        c = p_crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        p_crc = c;
    endfunction

    function automatic void goto_state(parse_state_t s, int len);
        p_state = s;
        p_remain = len[7:0];
    endfunction

    function automatic void list_push(logic [7:0] b);
        if (p_fill < CAPACITY)
        begin
            p_fill++;
            if (n_pushed < 2)
                pushed[n_pushed] = b;
            n_pushed++;
        end
    endfunction

    function automatic void take_node();
        if (p_nodes[p_level] > 0)
            p_nodes[p_level]--;
    endfunction

    // level after empty levels are popped
    function automatic int open_level();
        int l;
        l = p_level;
        while (l > 0 && p_nodes[l] == 0)
            l--;
        return l;
    endfunction

    function automatic void decode_tl(logic [7:0] b);
        logic [7:0] size;
        logic [7:0] hi;
        parse_state_t st;
        p_level = 4'(open_level());
        if (b > 8'h70 && b < 8'h7F)
        begin
            size = {4'h0, b[3:0]};
            take_node();
            if (p_level < DEPTH)
                p_level++;
            p_nodes[p_level] = size[3:0];
            goto_state(ST_LISTSTART, size);
            if (size > 5)
            begin
                p_fill = 0;
                cleared = 1'b1;
            end
            else
            begin
                list_push(size);
                list_push(8'(p_state));
            end
        end
        else if (b >= 8'h01 && b <= 8'h6F && p_nodes[p_level] > 0)
        begin
            if (b == 8'h01)
            begin
                list_push(8'h00);
                list_push(8'(p_state));
                if (p_nodes[p_level] == 1)
                    goto_state(ST_LISTEND, 1);
                else
                    goto_state(ST_NEXT, 1);
            end
            else
            begin
                hi = b & 8'hF0;
                size = {4'h0, b[3:0]} - 8'd1;
                st = ST_DATA;
                if (hi == 8'h50)
                    st = ST_SIGNED;
                else if (hi == 8'h60)
                    st = ST_UNSIGNED;
                else if (hi == 8'h00)
                    st = ST_OCTET;
                goto_state(st, size);
                list_push(size);
                list_push(8'(p_state));
            end
            take_node();
        end
        else if (b == 8'h00)
        begin
            take_node();
            if (p_level == 0)
                goto_state(ST_NEXT, 1);
            else
                goto_state(ST_BLOCKEND, 1);
        end
        else if (b >= 8'h80 && b <= 8'h8F)
            goto_state(ST_LONGLEN, {b[3:0], 4'h0});
        else if (b == ESC_BYTE && p_level == 0)
            goto_state(ST_END, 3);
        else
            goto_state(ST_UNEXPECTED, 4);
    endfunction

    function automatic void parser_reset();
        p_state = ST_START;
        p_remain = 8'd4;
        p_crc = CRC_PRESET;
        p_crc_calc = '0;
        p_crc_rcvd = '0;
        p_level = '0;
        for (int i = 0; i <= DEPTH; i++)
            p_nodes[i] = '0;
        p_fill = '0;
    endfunction

    function automatic parse_result_t parse_byte(logic [7:0] b);
        parse_result_t r;
        logic [7:0] size;
        n_pushed = 0;
        pushed[0] = 8'h00;
        pushed[1] = 8'h00;
        cleared = 1'b0;
        if (p_remain > 0)
            p_remain--;
        crc_byte(b);
        case (p_state)
            ST_VERSION:
            begin
                if (b != 8'h01)
                    goto_state(ST_UNEXPECTED, 4);
                if (p_remain == 0)
                    goto_state(ST_BLOCKSTART, 1);
            end
            ST_END:
            begin
                if (b != ESC_BYTE)
                    goto_state(ST_UNEXPECTED, 4);
                if (p_remain == 0)
                    goto_state(ST_CHECKSUM, 4);
            end
            ST_CHECKSUM:
            begin
                if (p_remain == 2)
                    p_crc_calc = p_crc ^ 16'hFFFF;
                if (p_remain == 1)
                    p_crc_rcvd = p_crc_rcvd + {8'h00, b};
                if (p_remain == 0)
                begin
                    p_crc_rcvd = p_crc_rcvd | {b, 8'h00};
                    if (p_crc_calc == p_crc_rcvd)
                        goto_state(ST_FINAL, 4);
                    else
                        goto_state(ST_CRCERROR, 4);
                    p_crc = CRC_PRESET;
                    p_crc_rcvd = '0;
                end
            end
            ST_LONGLEN:
            begin
                size = p_remain + b - 8'd1;
                goto_state(ST_DATA, size);
                list_push(size);
                list_push(8'(p_state));
            end
            ST_DATA, ST_SIGNED, ST_UNSIGNED, ST_OCTET:
            begin
                list_push(b);
                if (p_nodes[p_level] == 0 && p_remain == 0)
                    p_state = ST_LISTEND;
                else if (p_remain == 0)
                    p_state = ST_DATAEND;
            end
            ST_DATAEND, ST_NEXT, ST_LISTSTART, ST_LISTEND, ST_BLOCKSTART, ST_BLOCKEND:
                decode_tl(b);
            default:
            begin
                p_state = ST_START;
                p_level = 0;
                if (b != ESC_BYTE)
                    goto_state(ST_UNEXPECTED, 4);
                if (p_remain == 0)
                begin
                    p_crc = CRC_PRESET;
                    for (int i = 0; i < 4; i++)
                        crc_byte(ESC_BYTE);
                    goto_state(ST_VERSION, 4);
                end
            end
        endcase
        r.st = p_state;
        r.level = p_level;
        r.clear = cleared;
        r.count = (n_pushed > 2) ? 2'd2 : 2'(n_pushed);
        r.first = pushed[0];
        r.second = pushed[1];
        r.fill = p_fill;
        return r;
    endfunction

    // one input beat, with bursts and gaps on the sender side
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.data = b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    task automatic send_start_escape();
        repeat (4) send_byte(ESC_BYTE);
        repeat (4) send_byte(8'h01);
    endtask

    // end escape, pad byte and checksum, optionally corrupted
    task automatic send_end_escape(bit corrupt);
        logic [15:0] c;
        repeat (4) send_byte(ESC_BYTE);
        send_byte(8'h1A);
        send_byte(8'($urandom_range(0, 3)));
        c = p_crc_calc;
        if (corrupt)
            c ^= 16'(1 << $urandom_range(0, 15));
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    // pick a type-length byte or data byte fitting the shadow state
    function automatic logic [7:0] pick_token();
        int r;
        r = $urandom_range(0, 99);
        if (p_state inside {ST_DATA, ST_SIGNED, ST_UNSIGNED, ST_OCTET})
            return 8'($urandom);
        if (p_state == ST_LONGLEN)
            return 8'($urandom_range(0, 15));
        if (r < 15) return 8'($urandom_range(8'h71, 8'h75));
        if (r < 20) return 8'($urandom_range(8'h76, 8'h7E));
        if (r < 30) return 8'h01;
        if (r < 45) return 8'($urandom_range(8'h62, 8'h65));
        if (r < 55) return 8'($urandom_range(8'h52, 8'h55));
        if (r < 65) return 8'($urandom_range(8'h02, 8'h08));
        if (r < 68) return 8'($urandom_range(8'h80, 8'h81));
        if (r < 73) return 8'h00;
        if (r < 76) return 8'($urandom_range(8'h12, 8'h4F));
        if (r < 77) return 8'($urandom);
        return 8'($urandom_range(8'h62, 8'h64));
    endfunction

    // one message with random content; closes open levels before the escape
    task automatic send_random_frame();
        int budget;
        int guard;
        budget = $urandom_range(10, 60);
        send_start_escape();
        repeat (budget) send_byte(pick_token());
        guard = 0;
        while (guard < 200 && !(p_state inside {ST_DATAEND, ST_NEXT, ST_LISTSTART,
               ST_LISTEND, ST_BLOCKSTART, ST_BLOCKEND} && open_level() == 0))
        begin
            if (p_state inside {ST_DATA, ST_SIGNED, ST_UNSIGNED, ST_OCTET, ST_LONGLEN})
                send_byte(pick_token());
            else if (p_state inside {ST_DATAEND, ST_NEXT, ST_LISTSTART, ST_LISTEND,
                     ST_BLOCKSTART, ST_BLOCKEND})
                send_byte(8'h00);
            else
                break;
            guard++;
        end
        send_end_escape($urandom_range(0, 7) == 0);
    endtask

    task automatic test_good_frame();
        send_start_escape();
        send_byte(8'h76);
        send_byte(8'h05); repeat (4) send_byte(8'($urandom));
        send_byte(8'h62); send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h72);
        send_byte(8'h63); send_byte(8'hFF); send_byte(8'h80);
        send_byte(8'h55); repeat (4) send_byte(8'h7F);
        send_byte(8'h81); send_byte(8'h03); repeat (17) send_byte(8'($urandom));
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_end_escape(1'b0);
    endtask

    task automatic test_bad_checksum();
        send_start_escape();
        send_byte(8'h71);
        send_byte(8'h01);
        send_byte(8'h00);
        send_end_escape(1'b1);
    endtask

    task automatic test_deepest_level();
        send_start_escape();
        repeat (DEPTH + 1) send_byte(8'h71);
        send_byte(8'h60);
        repeat (20) send_byte(8'hFF);
        repeat (8) send_byte(8'h00);
        send_byte(8'h1B);
    endtask

    task automatic test_noise();
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h7F); send_byte(8'h70);
        repeat (3) send_byte(ESC_BYTE);
        send_byte(8'h02);
        repeat (4) send_byte(ESC_BYTE);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h01); send_byte(8'h01);
        send_byte(8'h8F); send_byte(8'h90); send_byte(8'hA5);
        send_byte(8'h1B); send_byte(8'h00);
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom));
    endtask

    task automatic test_random_frames();
        while (bytes_sent < 700)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            else
                send_random_frame();
        end
    endtask

    task automatic test_receiver_hold();
        hold_req = 1;
        repeat (3) send_random_frame();
    endtask

    // receiver: random stall rate that shifts over time, plus one long hold
    int stall_pct = 0;
    int phase_cnt = 0;
    int hold_cnt = 0;
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (phase_cnt == 0)
        begin
            phase_cnt = $urandom_range(50, 300);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        end
        phase_cnt--;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // result check
    always @(posedge clk)
    begin
        parse_result_t got;
        parse_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.st != exp_r.st)
                begin
                    $error("parse_state: expected %0d, got %0d", exp_r.st, got.st);
                    errors++;
                end
                if (got.level != exp_r.level)
                begin
                    $error("tree_level: expected %0d, got %0d", exp_r.level, got.level);
                    errors++;
                end
                if (got.clear != exp_r.clear)
                begin
                    $error("list_clear: expected %0d, got %0d", exp_r.clear, got.clear);
                    errors++;
                end
                if (got.count != exp_r.count)
                begin
                    $error("push_count: expected %0d, got %0d", exp_r.count, got.count);
                    errors++;
                end
                if (got.first != exp_r.first)
                begin
                    $error("push_first: expected %h, got %h", exp_r.first, got.first);
                    errors++;
                end
                if (got.second != exp_r.second)
                begin
                    $error("push_second: expected %h, got %h", exp_r.second, got.second);
                    errors++;
                end
                if (got.fill != exp_r.fill)
                begin
                    $error("list_position: expected %0d, got %0d", exp_r.fill, got.fill);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sml_stream_parser_crc16 test failed");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = 8'h00;
        parser_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_good_frame();
        test_bad_checksum();
        test_deepest_level();
        test_noise();
        test_receiver_hold();
        test_random_frames();

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("sml_stream_parser_crc16 test passed");
        else
            $display("sml_stream_parser_crc16 test failed");
        $finish;
    end
endmodule
